/* sv/kftr_pkg.sv */
// Package: widths, table entry type and key hash for the frequency mode tracker.
`timescale 1ns / 1ps
package kftr_pkg;
   localparam int ENTRIES    = 1024;
   localparam int ADDR_W     = $clog2(ENTRIES);
   localparam int KEY_W      = 37;
   localparam int COUNT_W    = 32;
   localparam int TIE_W      = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TIE_W-1:0]   TIE_MAX   = {TIE_W{1'b1}};
   localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(ENTRIES - 1);
   localparam logic ACT_COUNT  = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Fold the key into a table index, ADDR_W bits at a time.
   function automatic logic [ADDR_W-1:0] key_hash(input logic [KEY_W-1:0] key);
      logic [ADDR_W-1:0] h;
      logic [ADDR_W-1:0] part;
      h = '0;
      for (int i = 0; i < KEY_W; i += ADDR_W) begin
         part = '0;
         for (int b = 0; b < ADDR_W; b++) begin
            if (i + b < KEY_W) part[b] = key[i + b];
         end
         h = h ^ part;
      end
      return h;
   endfunction
endpackage

/* sv/kftr_if.sv */
// Channel interfaces: call record requests and leader report responses.
`timescale 1ns / 1ps
interface kftr_req_if;
   import kftr_pkg::*;
   logic             valid;
   logic             ready;
   logic             action;
   logic [KEY_W-1:0] caller_number;
   logic [KEY_W-1:0] callee_number;
   modport source (output valid, action, caller_number, callee_number, input ready);
   modport sink   (input valid, action, caller_number, callee_number, output ready);
endinterface

interface kftr_rsp_if;
   import kftr_pkg::*;
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   leader_number;
   logic [COUNT_W-1:0] leader_count;
   logic [TIE_W-1:0]   tie_total;
   logic               overflowed;
   modport source (output valid, leader_number, leader_count, tie_total, overflowed,
                   input ready);
   modport sink   (input valid, leader_number, leader_count, tie_total, overflowed,
                   output ready);
endinterface

/* sv/kftr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module kftr_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/key_frequency_mode_tracker.sv */
// A count transaction probes the hashed table for the caller and then for the callee, each
// probe passing through a read state and a compare state; probing chains are bounded by
// the table depth (one RAM read per probe). A new transaction is taken only in the idle
// state, with the report register free or being read. A report transaction is answered
// through a held output register. Reset is synchronous; afterwards a clearing pass over
// all 1024 entries invalidates the table, and no transaction is taken until it ends.
`timescale 1ns / 1ps
module key_frequency_mode_tracker (
   input logic clock,
   input logic reset,
   kftr_req_if.sink   req,
   kftr_rsp_if.source rsp
);
   import kftr_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CMP   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  probe_ff, probe_in;
   logic               sel_ff, sel_in;
   logic [KEY_W-1:0]   caller_ff, caller_in;
   logic [KEY_W-1:0]   callee_ff, callee_in;
   logic [COUNT_W-1:0] max_ff, max_in;
   logic [KEY_W-1:0]   best_ff, best_in;
   logic [TIE_W-1:0]   tie_ff, tie_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]   rsp_num_ff, rsp_num_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [TIE_W-1:0]   rsp_tie_ff, rsp_tie_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   entry_type          wr_entry;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_bits;
   logic [KEY_W-1:0]   cur_key;
   logic               bump;
   logic [COUNT_W-1:0] now;
   logic               finish;
   logic               take;

   kftr_ram #(.WIDTH(ENTRY_W), .ADDR_W(ADDR_W)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (addr_ff),
      .rd_data (rd_bits)
   );

   assign rd_entry  = entry_type'(rd_bits);
   assign cur_key   = sel_ff ? callee_ff : caller_ff;
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign take      = req.valid && req.ready;

   // Probe, insert and leader tracking
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      probe_in     = probe_ff;
      sel_in       = sel_ff;
      caller_in    = caller_ff;
      callee_in    = callee_ff;
      max_in       = max_ff;
      best_in      = best_ff;
      tie_in       = tie_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_tie_in   = rsp_tie_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_entry     = '0;
      bump         = 1'b0;
      now          = '0;
      finish       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (take) begin
               if (req.action == ACT_REPORT) begin
                  rsp_valid_in = 1'b1;
                  rsp_num_in   = best_ff;
                  rsp_cnt_in   = max_ff;
                  rsp_tie_in   = tie_ff;
                  rsp_ovf_in   = ovf_ff;
               end else begin
                  caller_in = req.caller_number;
                  callee_in = req.callee_number;
                  sel_in    = 1'b0;
                  probe_in  = '0;
                  addr_in   = key_hash(req.caller_number);
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (rd_entry.valid && rd_entry.key == cur_key) begin
               if (rd_entry.count != COUNT_MAX) begin
                  bump = 1'b1;
                  now  = rd_entry.count + 1'b1;
               end
               finish = 1'b1;
            end else if (!rd_entry.valid) begin
               bump   = 1'b1;
               now    = COUNT_W'(1);
               finish = 1'b1;
            end else if (probe_ff == LAST_SLOT) begin
               ovf_in = 1'b1;
               finish = 1'b1;
            end else begin
               probe_in = probe_ff + 1'b1;
               addr_in  = addr_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Write back the raised count and update the leader
      if (bump) begin
         wr_en          = 1'b1;
         wr_entry.valid = 1'b1;
         wr_entry.key   = cur_key;
         wr_entry.count = now;
         if (now > max_ff) begin
            max_in  = now;
            best_in = cur_key;
            tie_in  = TIE_W'(1);
         end else if (now == max_ff) begin
            if (tie_ff != TIE_MAX) tie_in = tie_ff + 1'b1;
            if (cur_key < best_ff) best_in = cur_key;
         end
      end

      // Move on to the callee, or back to idle
      if (finish) begin
         if (!sel_ff) begin
            sel_in   = 1'b1;
            probe_in = '0;
            addr_in  = key_hash(callee_ff);
            state_in = ST_READ;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         max_ff       <= '0;
         best_ff      <= '0;
         tie_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         max_ff       <= max_in;
         best_ff      <= best_in;
         tie_ff       <= tie_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      probe_ff   <= probe_in;
      caller_ff  <= caller_in;
      callee_ff  <= callee_in;
      rsp_num_ff <= rsp_num_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_tie_ff <= rsp_tie_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.leader_number = rsp_num_ff;
   assign rsp.leader_count  = rsp_cnt_ff;
   assign rsp.tie_total     = rsp_tie_ff;
   assign rsp.overflowed    = rsp_ovf_ff;
endmodule

/* verif/tb_key_frequency_mode_tracker.sv */
// Testbench: call record counting, leader reports and table overflow of the mode tracker.
`timescale 1ns / 1ps
module tb_key_frequency_mode_tracker;
   import kftr_pkg::*;

   localparam int LIMIT_CYCLES = 30_000_000;
   localparam int RANDOM_ITEMS = 1100;
   localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] MAX_DIGITS = 37'd99999999999;

   typedef struct packed {
      logic [KEY_W-1:0]   leader_number;
      logic [COUNT_W-1:0] leader_count;
      logic [TIE_W-1:0]   tie_total;
      logic               overflowed;
   } report_type;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] caller_number;
      logic [KEY_W-1:0] callee_number;
      logic             fixed;     // expected report typed in below
      report_type       fixed_rpt;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kftr_req_if req ();
   kftr_rsp_if rsp ();

   key_frequency_mode_tracker dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always #10 clock = ~clock;

   // Predicted tracker state
   logic [COUNT_W-1:0] call_count [logic [KEY_W-1:0]];
   int                 keys_held;
   logic [COUNT_W-1:0] top_count;
   logic [KEY_W-1:0]   top_key;
   logic [TIE_W-1:0]   top_ties;
   logic               table_overflow;

   report_type pending_reports [$];
   row_type    sent_rows [$];   // rows in flight, matched at acceptance
   int         errors = 0;
   int         accepted = 0;
   bit         long_hold_done = 1'b0;
   longint     cycles = 0;

   // Count one number, inserting it while there is room
   task automatic count_number(input logic [KEY_W-1:0] key);
      logic [COUNT_W-1:0] now;
      if (!call_count.exists(key)) begin
         if (keys_held >= ENTRIES) begin
            table_overflow = 1'b1;
            return;
         end
         call_count[key] = '0;
         keys_held++;
      end
      if (call_count[key] == COUNT_MAX) return;
      now = call_count[key] + 1'b1;
      call_count[key] = now;
      if (now > top_count) begin
         top_count = now;
         top_key   = key;
         top_ties  = TIE_W'(1);
      end else if (now == top_count) begin
         if (top_ties != TIE_MAX) top_ties++;
         if (key < top_key) top_key = key;
      end
   endtask

   task automatic predict_tracker(input row_type r);
      report_type rpt;
      if (r.action == ACT_COUNT) begin
         count_number(r.caller_number);
         count_number(r.callee_number);
      end else begin
         rpt.leader_number = top_key;
         rpt.leader_count  = top_count;
         rpt.tie_total     = top_ties;
         rpt.overflowed    = table_overflow;
         pending_reports.push_back(r.fixed ? r.fixed_rpt : rpt);
      end
   endtask

   // Transactions seen at the clock edge: predict inputs, check outputs
   always @(posedge clock) begin
      report_type want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (req.valid && req.ready) begin
            accepted <= accepted + 1;
            predict_tracker(sent_rows.pop_front());
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_reports.size() == 0) begin
               $error("unexpected report: number %0d count %0d",
                      rsp.leader_number, rsp.leader_count);
               errors++;
            end else begin
               want = pending_reports.pop_front();
               if (rsp.leader_number !== want.leader_number) begin
                  $error("leader_number: expected %0d, got %0d",
                         want.leader_number, rsp.leader_number);
                  errors++;
               end
               if (rsp.leader_count !== want.leader_count) begin
                  $error("leader_count: expected %0d, got %0d",
                         want.leader_count, rsp.leader_count);
                  errors++;
               end
               if (rsp.tie_total !== want.tie_total) begin
                  $error("tie_total: expected %0d, got %0d",
                         want.tie_total, rsp.tie_total);
                  errors++;
               end
               if (rsp.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0d, got %0d",
                         want.overflowed, rsp.overflowed);
                  errors++;
               end
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: changing stall pattern, plus one long hold-off
   always @(posedge clock) begin
      int mode;
      int hold_left;
      if (reset) begin
         rsp.ready <= 1'b0;
         mode = 0;
         hold_left = 0;
      end else begin
         if (!long_hold_done && accepted > 300) begin
            long_hold_done = 1'b1;
            hold_left = 400;
         end
         if (cycles % 97 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= ($urandom_range(0, 3) != 0);
               2: rsp.ready <= ($urandom_range(0, 1) != 0);
               default: rsp.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Sender: bursts with random gaps
   int burst_left = 0;

   task automatic offer(input row_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      sent_rows.push_back(r);
      req.valid         <= 1'b1;
      req.action        <= r.action;
      req.caller_number <= r.caller_number;
      req.callee_number <= r.callee_number;
      do @(posedge clock); while (!req.ready);
   endtask

   // Key sources: a hot pool for repeats, fresh keys to fill the table
   logic [KEY_W-1:0] hot_keys [48];

   function automatic logic [KEY_W-1:0] any_key();
      return {5'($urandom_range(0, 31)), 32'($urandom)};
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
      if ($urandom_range(0, 99) < fresh_pct) begin
         if ($urandom_range(0, 1)) return any_key();
         return KEY_W'({$urandom, $urandom} % (64'(MAX_DIGITS) + 1));
      end
      return hot_keys[$urandom_range(0, 47)];
   endfunction

   function automatic row_type count_row(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      row_type r;
      r = '0;
      r.action = ACT_COUNT;
      r.caller_number = a;
      r.callee_number = b;
      return r;
   endfunction

   function automatic row_type report_row(input logic fixed, input report_type rpt);
      row_type r;
      r = '0;
      r.action = ACT_REPORT;
      r.caller_number = any_key();
      r.callee_number = any_key();
      r.fixed = fixed;
      r.fixed_rpt = rpt;
      return r;
   endfunction

   row_type directed [$];

   initial begin
      row_type r;
      int fresh_pct;
      req.valid = 1'b0;
      req.action = ACT_COUNT;
      req.caller_number = '0;
      req.callee_number = '0;
      keys_held = 0;
      top_count = '0;
      top_key = '0;
      top_ties = '0;
      table_overflow = 1'b0;
      hot_keys[0] = '0;
      hot_keys[1] = KEY_ONES;
      hot_keys[2] = MAX_DIGITS;
      hot_keys[3] = 37'd1;
      for (int i = 4; i < 48; i++) hot_keys[i] = any_key();

      // Directed rows: report at reset, extremes, self calls, ties
      directed.push_back(report_row(1'b1, '0));
      directed.push_back(count_row('0, '0));
      directed.push_back(report_row(1'b1, {37'd0, 32'd2, 11'd1, 1'b0}));
      directed.push_back(count_row(KEY_ONES, KEY_ONES));
      directed.push_back(report_row(1'b1, {37'd0, 32'd2, 11'd2, 1'b0}));
      directed.push_back(count_row(MAX_DIGITS, 37'd1));
      directed.push_back(report_row(1'b0, '0));
      directed.push_back(count_row(MAX_DIGITS, MAX_DIGITS));
      directed.push_back(report_row(1'b1, {MAX_DIGITS, 32'd3, 11'd1, 1'b0}));
      directed.push_back(count_row(37'd1, 37'd1));
      directed.push_back(report_row(1'b1, {37'd1, 32'd3, 11'd2, 1'b0}));
      directed.push_back(count_row(37'h0AAAAAAAAA, 37'h1555555555));
      directed.push_back(count_row('0, KEY_ONES));
      directed.push_back(report_row(1'b0, '0));
      directed.push_back(count_row('0, 37'd1));
      directed.push_back(report_row(1'b0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) offer(directed[i]);

      // Random part: fill the table early, then mostly repeats past overflow
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         fresh_pct = (n < 800) ? 90 : 8;
         if ($urandom_range(0, 4) == 0) r = report_row(1'b0, '0);
         else if ($urandom_range(0, 19) == 0) begin
            r = count_row(pick_key(fresh_pct), '0);
            r.callee_number = r.caller_number;
         end else r = count_row(pick_key(fresh_pct), pick_key(fresh_pct));
         offer(r);
      end
      // A closing report after overflow
      offer(report_row(1'b0, '0));
      req.valid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
